// File: rtl/frs_pkg.sv
// Shared constants, register codes and result type for the rejection sampler.
package frs_pkg;

  // Candidate and polynomial geometry.
  localparam int unsigned CAND_W          = 12;
  localparam int unsigned COUNT_W         = 9;
  localparam int unsigned SLOT_W          = 8;
  localparam int unsigned POLY_W          = 4;
  localparam int unsigned PCOUNT_W        = 5;

  localparam logic [COUNT_W-1:0]  COEFFS_PER_POLY = 9'd256;
  localparam logic [CAND_W:0]     MODULUS         = 13'd3329;
  localparam logic [PCOUNT_W-1:0] MAX_POLYS       = 5'd16;

  // Register file.
  localparam int unsigned CFG_DATA_W  = 9;
  localparam int unsigned CFG_INDEX_W = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GROUPS_PER_POLY  = 1'b0,
    REG_POLYS_PER_MATRIX = 1'b1
  } cfg_reg_t;

  localparam logic [COUNT_W-1:0]  GROUPS_RESET = 9'd280;
  localparam logic [PCOUNT_W-1:0] POLYS_RESET  = 5'd9;

  // Stream widths.
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 56;

  typedef struct packed {
    logic [COUNT_W-1:0]  groups_per_poly;
    logic [PCOUNT_W-1:0] polys_per_matrix;
  } cfg_t;

  typedef struct packed {
    logic [CAND_W-1:0] first_coef;
    logic              first_valid;
    logic [SLOT_W-1:0] first_slot;
    logic [CAND_W-1:0] second_coef;
    logic              second_valid;
    logic [SLOT_W-1:0] second_slot;
    logic [POLY_W-1:0] poly_number;
    logic              poly_done;
    logic              poly_short;
    logic              matrix_done;
    logic              matrix_fail;
  } result_t;

endpackage

// File: rtl/frs_cfg.sv
// Configuration registers: group count per polynomial and polynomials per matrix.
module frs_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [frs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [frs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output frs_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.groups_per_poly  <= frs_pkg::GROUPS_RESET;
      cfg.polys_per_matrix <= frs_pkg::POLYS_RESET;
    end else if (cfg_we) begin
      case (frs_pkg::cfg_reg_t'(cfg_index))
        frs_pkg::REG_GROUPS_PER_POLY: begin
          cfg.groups_per_poly <= cfg_data[frs_pkg::COUNT_W-1:0];
        end
        frs_pkg::REG_POLYS_PER_MATRIX: begin
          cfg.polys_per_matrix <= cfg_data[frs_pkg::PCOUNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/frs_core.sv
// Candidate acceptance, slot allocation and polynomial/matrix bookkeeping.
module frs_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  logic [frs_pkg::IN_DATA_W-1:0]   byte_group,
  input  frs_pkg::cfg_t                   cfg,
  output frs_pkg::result_t                result
);

  logic [frs_pkg::COUNT_W-1:0]  filled_slots, filled_slots_next;
  logic [frs_pkg::COUNT_W-1:0]  groups_taken, groups_taken_next;
  logic [frs_pkg::POLY_W-1:0]   poly_counter, poly_counter_next;
  logic                         sticky_fail, sticky_fail_next;

  logic [frs_pkg::CAND_W-1:0]   cand0, cand1;
  logic                         ok0, ok1;
  logic [frs_pkg::COUNT_W-1:0]  fill1, fill2, gt_inc, glimit;
  logic [frs_pkg::PCOUNT_W-1:0] plimit, pc_inc;
  logic                         pdone, pshort, mdone, fail_acc;

  always_comb begin
    cand0 = byte_group[frs_pkg::CAND_W-1:0];
    cand1 = byte_group[2*frs_pkg::CAND_W-1:frs_pkg::CAND_W];

    ok0   = ({1'b0, cand0} < frs_pkg::MODULUS) && (filled_slots < frs_pkg::COEFFS_PER_POLY);
    fill1 = filled_slots + frs_pkg::COUNT_W'(ok0);
    ok1   = ({1'b0, cand1} < frs_pkg::MODULUS) && (fill1 < frs_pkg::COEFFS_PER_POLY);
    fill2 = fill1 + frs_pkg::COUNT_W'(ok1);

    // zero counts act as one; matrix size capped
    glimit = (cfg.groups_per_poly == '0) ? frs_pkg::COUNT_W'(1) : cfg.groups_per_poly;
    if (cfg.polys_per_matrix == '0) begin
      plimit = frs_pkg::PCOUNT_W'(1);
    end else if (cfg.polys_per_matrix > frs_pkg::MAX_POLYS) begin
      plimit = frs_pkg::MAX_POLYS;
    end else begin
      plimit = cfg.polys_per_matrix;
    end

    gt_inc   = groups_taken + frs_pkg::COUNT_W'(1);
    pc_inc   = {1'b0, poly_counter} + frs_pkg::PCOUNT_W'(1);
    pdone    = gt_inc >= glimit;
    pshort   = pdone && (fill2 < frs_pkg::COEFFS_PER_POLY);
    fail_acc = sticky_fail | pshort;
    mdone    = pdone && (pc_inc >= plimit);

    filled_slots_next = pdone ? '0 : fill2;
    groups_taken_next = pdone ? '0 : gt_inc;
    poly_counter_next = mdone ? '0 : (pdone ? pc_inc[frs_pkg::POLY_W-1:0] : poly_counter);
    sticky_fail_next  = mdone ? 1'b0 : fail_acc;

    result.first_coef   = ok0 ? cand0 : '0;
    result.first_valid  = ok0;
    result.first_slot   = ok0 ? filled_slots[frs_pkg::SLOT_W-1:0] : '0;
    result.second_coef  = ok1 ? cand1 : '0;
    result.second_valid = ok1;
    result.second_slot  = ok1 ? fill1[frs_pkg::SLOT_W-1:0] : '0;
    result.poly_number  = poly_counter;
    result.poly_done    = pdone;
    result.poly_short   = pshort;
    result.matrix_done  = mdone;
    result.matrix_fail  = mdone && fail_acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled_slots <= '0;
      groups_taken <= '0;
      poly_counter <= '0;
      sticky_fail  <= 1'b0;
    end else if (advance) begin
      filled_slots <= filled_slots_next;
      groups_taken <= groups_taken_next;
      poly_counter <= poly_counter_next;
      sticky_fail  <= sticky_fail_next;
    end
  end

endmodule

// File: rtl/fixed_iteration_rejection_sampler_unit.sv
// Top level of the fixed-iteration rejection sampler: stream ports and pipeline registers.
//
//  channel | direction | fields
//  --------+-----------+-------------------------------------------------------------
//  s_axis  | in        | tdata: byte_group[23:0]
//  m_axis  | out       | tdata: coefficients, slots, polynomial status; tlast: matrix_done
//  cfg     | in        | cfg_we/cfg_index/cfg_data: 0 groups_per_poly, 1 polys_per_matrix
//
// Two register stages: the input register holds one byte group, the candidate
// checks and counter updates sit between it and the result register.
// One transaction per cycle sustained while m_axis_tready stays high.
// rst (synchronous) empties both stages, clears the counters and loads the
// register defaults (280 groups, 9 polynomials). A stall on m_axis holds the
// result and lets the input stage fill before s_axis_tready drops.
module fixed_iteration_rejection_sampler_unit (
  input  logic                             clk,
  input  logic                             rst,
  // byte_group[23:0]
  input  logic [frs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // first_coef[11:0], first_valid[12], first_slot[20:13], second_coef[32:21],
  // second_valid[33], second_slot[41:34], poly_number[45:42], poly_done[46],
  // poly_short[47], matrix_fail[48], zero [55:49]
  output logic [frs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // matrix_done
  output logic                             m_axis_tlast,
  input  logic                             cfg_we,
  input  logic [frs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [frs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  frs_pkg::cfg_t                  cfg;
  frs_pkg::result_t               result;
  frs_pkg::result_t               out_reg;

  logic [frs_pkg::IN_DATA_W-1:0]  in_data;
  logic                           in_valid;
  logic                           out_valid;
  logic                           advance;

  // Input stage moves on whenever the result register is free or draining.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  frs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  frs_core u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .byte_group (in_data),
    .cfg        (cfg),
    .result     (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data <= s_axis_tdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_reg.matrix_done;
  assign m_axis_tdata  = {7'b0,
                          out_reg.matrix_fail,
                          out_reg.poly_short,
                          out_reg.poly_done,
                          out_reg.poly_number,
                          out_reg.second_slot,
                          out_reg.second_valid,
                          out_reg.second_coef,
                          out_reg.first_slot,
                          out_reg.first_valid,
                          out_reg.first_coef};

endmodule
